@@ design/srtc_pkg.sv @@
// Shared types, constants and helpers for the steering rate limit and turn cancel unit.
package srtc_pkg;

    // Axis word width; the axis is Q1.(AXIS_BITS-1) two's complement.
    localparam int AXIS_BITS      = 16;

    localparam int DT_BITS        = 20;
    localparam int ANGLE_BITS     = 18;
    localparam int RATE_BITS      = 28;
    localparam int IND_BITS       = 2;
    localparam int MWA_BITS       = 17;
    localparam int MRATE_BITS     = 24;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Rate divider geometry: 44-bit dividend, 20-bit divisor, 29 quotient bits.
    localparam int DIV_NUM_BITS   = 44;
    localparam int DIV_DEN_BITS   = 20;
    localparam int DIV_QUO_BITS   = 29;

    localparam int DELTA_BITS     = 25;
    localparam int DIFF_BITS      = ANGLE_BITS + 1;
    localparam int RNUM_BITS      = 38;

    localparam logic [DT_BITS-1:0]      DT_MIN_US = 20'd1000;
    localparam logic [DIV_DEN_BITS-1:0] US_PER_S  = 20'd1000000;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_LIMIT_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_WHEEL_ANGLE   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RATE          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LATCH_ON_ANGLE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_ANGLE     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RETURN_RATE_MIN   = 3'd5;

    // Indicator codes.
    localparam logic [IND_BITS-1:0] IND_OFF    = 2'd0;
    localparam logic [IND_BITS-1:0] IND_LEFT   = 2'd1;
    localparam logic [IND_BITS-1:0] IND_RIGHT  = 2'd2;
    localparam logic [IND_BITS-1:0] IND_HAZARD = 2'd3;

    // Button bit positions in the button history.
    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_HAZARD = 2;

    typedef struct packed {
        logic signed [AXIS_BITS-1:0] steer_axis;
        logic [DT_BITS-1:0]          elapsed_us;
        logic                        remote_active;
        logic                        left_button;
        logic                        right_button;
        logic                        hazard_button;
    } in_word_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] wheel_angle;
        logic [RATE_BITS-1:0]         angle_rate;
        logic [IND_BITS-1:0]          indicator;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic load_prod;
        logic div_start;
        logic load_delta;
        logic load_angle;
        logic load_diff;
        logic load_mul2;
        logic load_rate;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic remote;
        logic rate_limit;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } dp_sts_t;

    // A left or right press turns its own state off, else selects it unless hazard is on.
    function automatic logic [IND_BITS-1:0] press_toggle(
        input logic [IND_BITS-1:0] ind,
        input logic [IND_BITS-1:0] val
    );
        logic [IND_BITS-1:0] res;
        if (ind == val)
        begin
            res = IND_OFF;
        end
        else if (ind != IND_HAZARD)
        begin
            res = val;
        end
        else
        begin
            res = ind;
        end
        return res;
    endfunction

endpackage

@@ design/srtc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module srtc_div
    import srtc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIV_NUM_BITS-1:0] numer,
    input  logic [DIV_DEN_BITS-1:0] denom,
    output logic                    busy,
    output logic                    done,
    output logic [DIV_QUO_BITS-1:0] quotient
);

    localparam int CNT_BITS  = $clog2(DIV_QUO_BITS + 1);
    localparam int HEAD_BITS = DIV_NUM_BITS - DIV_QUO_BITS;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [DIV_DEN_BITS-1:0] rem_reg;
    logic [DIV_DEN_BITS-1:0] rem_next;
    logic [DIV_DEN_BITS-1:0] den_reg;
    logic [DIV_QUO_BITS-1:0] sh_reg;
    logic [DIV_DEN_BITS:0]   trial;
    logic [DIV_DEN_BITS:0]   trial_sub;
    logic                    qbit;

    // The dividend's high bits always sit below the divisor, so the quotient fits.
    assign trial     = {rem_reg, sh_reg[DIV_QUO_BITS-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign qbit      = (trial >= {1'b0, den_reg});
    assign rem_next  = qbit ? trial_sub[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIV_QUO_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(DIV_DEN_BITS-HEAD_BITS){1'b0}}, numer[DIV_NUM_BITS-1:DIV_QUO_BITS]};
            sh_reg  <= numer[DIV_QUO_BITS-1:0];
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[DIV_QUO_BITS-2:0], qbit};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

@@ design/srtc_dp.sv @@
// Datapath: configuration, scaling, rate clamp, rate divide, indicator logic and output register.
module srtc_dp
    import srtc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output dp_sts_t                   sts,
    input  in_word_t                  in_word,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_word_t                 out_word
);

    localparam int SCALE_BITS = AXIS_BITS + MWA_BITS;
    localparam int LIM_BITS   = DELTA_BITS + 2;
    localparam int CMP_BITS   = ANGLE_BITS + 1;
    localparam logic [SCALE_BITS-1:0] ROUND_HALF = SCALE_BITS'(1) << (AXIS_BITS - 2);

    // Reciprocal of 15625 scaled by 2^46; with the product shifted right by six first,
    // this gives floor(x / 1000000) exactly for every product below 2^38.
    localparam int RECIP_BITS  = 33;
    localparam int RECIP_SHIFT = 46;
    localparam int RPROD_BITS  = 32 + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_15625 = 33'd4503599628;
    localparam logic [DELTA_BITS-1:0] DELTA_SAT   = '1;

    // Configuration registers.
    logic                  cfg_rate_en_reg;
    logic [MWA_BITS-1:0]   cfg_max_wheel_reg;
    logic [MRATE_BITS-1:0] cfg_max_rate_reg;
    logic [MWA_BITS-1:0]   cfg_latch_reg;
    logic [MWA_BITS-1:0]   cfg_release_reg;
    logic [MRATE_BITS-1:0] cfg_ret_rate_reg;

    // Per-word working registers.
    logic signed [AXIS_BITS-1:0]  axis_reg;
    logic [DT_BITS-1:0]           dt_reg;
    logic                         remote_reg;
    logic [2:0]                   btn_reg;
    logic [SCALE_BITS-1:0]        scale_prod_reg;
    logic [DIV_NUM_BITS-1:0]      delta_prod_reg;
    logic [DELTA_BITS-1:0]        delta_reg;
    logic signed [ANGLE_BITS-1:0] angle_reg;
    logic [DIFF_BITS-1:0]         absdiff_reg;
    logic                         diff_neg_reg;
    logic                         diff_pos_reg;
    logic [RNUM_BITS-1:0]         rate_num_reg;
    logic [DIV_NUM_BITS-1:0]      rrm_dt_reg;
    logic [RATE_BITS-1:0]         rate_reg;
    logic                         fast_reg;

    // State carried from word to word.
    logic signed [ANGLE_BITS-1:0] prev_angle_reg;
    logic                         left_armed_reg;
    logic                         right_armed_reg;
    logic [IND_BITS-1:0]          ind_reg;
    logic [2:0]                   btn_hist_reg;

    logic                         out_valid_reg;
    out_word_t                    out_word_reg;

    // Combinational signals.
    logic                         axis_neg;
    logic [AXIS_BITS-1:0]         mag_axis;
    logic [SCALE_BITS-1:0]        round_sum;
    logic [MWA_BITS-1:0]          q_mag;
    logic signed [ANGLE_BITS-1:0] desired;
    logic [RPROD_BITS-1:0]        recip_prod;
    logic [DELTA_BITS-1:0]        delta_calc;
    logic signed [LIM_BITS-1:0]   prev_w;
    logic signed [LIM_BITS-1:0]   delta_w;
    logic signed [LIM_BITS-1:0]   desired_w;
    logic signed [LIM_BITS-1:0]   lim_lo;
    logic signed [LIM_BITS-1:0]   lim_hi;
    logic signed [LIM_BITS-1:0]   angle_lim;
    logic signed [DIFF_BITS-1:0]  diff;
    logic [DIV_NUM_BITS-1:0]      div_numer;
    logic [DIV_DEN_BITS-1:0]      div_denom;
    logic                         div_busy;
    logic                         div_done;
    logic [DIV_QUO_BITS-1:0]      div_quo;
    logic signed [CMP_BITS-1:0]   angle_c;
    logic signed [CMP_BITS-1:0]   latch_c;
    logic signed [CMP_BITS-1:0]   release_c;
    logic                         left_armed_next;
    logic                         right_armed_next;
    logic [IND_BITS-1:0]          ind_next;
    logic [2:0]                   rise;
    out_word_t                    out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rate_en_reg   <= 1'b0;
            cfg_max_wheel_reg <= MWA_BITS'(54000);
            cfg_max_rate_reg  <= MRATE_BITS'(15000);
            cfg_latch_reg     <= MWA_BITS'(7000);
            cfg_release_reg   <= MWA_BITS'(5000);
            cfg_ret_rate_reg  <= MRATE_BITS'(500);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RATE_LIMIT_ENABLE: cfg_rate_en_reg   <= cfg_data[0];
                CFG_MAX_WHEEL_ANGLE:   cfg_max_wheel_reg <= cfg_data[MWA_BITS-1:0];
                CFG_MAX_RATE:          cfg_max_rate_reg  <= cfg_data[MRATE_BITS-1:0];
                CFG_LATCH_ON_ANGLE:    cfg_latch_reg     <= cfg_data[MWA_BITS-1:0];
                CFG_RELEASE_ANGLE:     cfg_release_reg   <= cfg_data[MWA_BITS-1:0];
                CFG_RETURN_RATE_MIN:   cfg_ret_rate_reg  <= cfg_data[MRATE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Axis magnitude; the most negative code maps to exactly one.
    assign axis_neg = axis_reg[AXIS_BITS-1];
    assign mag_axis = axis_neg ? (~axis_reg + AXIS_BITS'(1)) : axis_reg;

    // Scaled angle, rounded half away from zero.
    assign round_sum = scale_prod_reg + ROUND_HALF;
    assign q_mag     = round_sum[AXIS_BITS+MWA_BITS-2:AXIS_BITS-1];
    assign desired   = axis_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    // Allowed step per word. A product of 2^38 or more allows a step beyond any
    // possible angle change, so it saturates and the clamp never acts.
    assign recip_prod = RPROD_BITS'(delta_prod_reg[DIV_NUM_BITS-7:6]) *
                        RPROD_BITS'(RECIP_15625);
    assign delta_calc = (delta_prod_reg[DIV_NUM_BITS-1:DIV_NUM_BITS-6] != '0) ? DELTA_SAT :
                        DELTA_BITS'(recip_prod[RPROD_BITS-1:RECIP_SHIFT]);

    assign prev_w    = LIM_BITS'(prev_angle_reg);
    assign delta_w   = $signed({2'b00, delta_reg});
    assign desired_w = LIM_BITS'(desired);
    assign lim_lo    = prev_w - delta_w;
    assign lim_hi    = prev_w + delta_w;
    assign angle_lim = (desired_w < lim_lo) ? lim_lo :
                       (desired_w > lim_hi) ? lim_hi : desired_w;

    assign diff = DIFF_BITS'(angle_reg) - DIFF_BITS'(prev_angle_reg);

    assign div_numer = DIV_NUM_BITS'(rate_num_reg);
    assign div_denom = dt_reg;

    srtc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            axis_reg   <= in_word.steer_axis;
            dt_reg     <= (in_word.elapsed_us < DT_MIN_US) ? DT_MIN_US : in_word.elapsed_us;
            remote_reg <= in_word.remote_active;
            btn_reg    <= {in_word.hazard_button, in_word.right_button, in_word.left_button};
        end
        if (cmd.load_prod)
        begin
            scale_prod_reg <= SCALE_BITS'(mag_axis) * SCALE_BITS'(cfg_max_wheel_reg);
            delta_prod_reg <= DIV_NUM_BITS'(cfg_max_rate_reg) * DIV_NUM_BITS'(dt_reg);
        end
        if (cmd.load_delta)
        begin
            delta_reg <= delta_calc;
        end
        if (cmd.load_angle)
        begin
            angle_reg <= cfg_rate_en_reg ? angle_lim[ANGLE_BITS-1:0] : desired;
        end
        if (cmd.load_diff)
        begin
            diff_neg_reg <= diff[DIFF_BITS-1];
            diff_pos_reg <= !diff[DIFF_BITS-1] && (diff != '0);
            absdiff_reg  <= diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
        end
        if (cmd.load_mul2)
        begin
            rate_num_reg <= RNUM_BITS'(absdiff_reg) * RNUM_BITS'(US_PER_S);
            rrm_dt_reg   <= DIV_NUM_BITS'(cfg_ret_rate_reg) * DIV_NUM_BITS'(dt_reg);
        end
        if (cmd.load_rate)
        begin
            rate_reg <= div_quo[RATE_BITS-1:0];
            fast_reg <= (DIV_NUM_BITS'(rate_num_reg) > rrm_dt_reg);
        end
    end

    assign angle_c   = CMP_BITS'(angle_reg);
    assign latch_c   = $signed({2'b00, cfg_latch_reg});
    assign release_c = $signed({2'b00, cfg_release_reg});
    assign rise      = btn_reg & ~btn_hist_reg;

    // Automatic cancel first, then button edges in the order left, right, hazard.
    always_comb
    begin
        left_armed_next  = left_armed_reg;
        right_armed_next = right_armed_reg;
        ind_next         = IND_OFF;
        out_next         = '0;
        if (remote_reg)
        begin
            left_armed_next  = left_armed_reg || (angle_c >= latch_c);
            right_armed_next = right_armed_reg || (angle_c <= -latch_c);
            ind_next         = ind_reg;
            case (ind_reg)
                IND_LEFT:
                begin
                    if (left_armed_next && (angle_c <= release_c) && diff_neg_reg && fast_reg)
                    begin
                        ind_next        = IND_OFF;
                        left_armed_next = 1'b0;
                    end
                end
                IND_RIGHT:
                begin
                    if (right_armed_next && (angle_c >= -release_c) && diff_pos_reg && fast_reg)
                    begin
                        ind_next         = IND_OFF;
                        right_armed_next = 1'b0;
                    end
                end
                default:
                begin
                    left_armed_next  = 1'b0;
                    right_armed_next = 1'b0;
                end
            endcase
            if (rise[BTN_LEFT])
            begin
                ind_next = press_toggle(ind_next, IND_LEFT);
            end
            if (rise[BTN_RIGHT])
            begin
                ind_next = press_toggle(ind_next, IND_RIGHT);
            end
            if (rise[BTN_HAZARD])
            begin
                ind_next = (ind_next == IND_HAZARD) ? IND_OFF : IND_HAZARD;
            end
            out_next.wheel_angle = angle_reg;
            out_next.angle_rate  = rate_reg;
            out_next.indicator   = ind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg  <= '0;
            left_armed_reg  <= 1'b0;
            right_armed_reg <= 1'b0;
            ind_reg         <= IND_OFF;
            btn_hist_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                ind_reg       <= ind_next;
                out_valid_reg <= 1'b1;
                if (remote_reg)
                begin
                    prev_angle_reg  <= angle_reg;
                    left_armed_reg  <= left_armed_next;
                    right_armed_reg <= right_armed_next;
                    btn_hist_reg    <= btn_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_word_reg <= out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_word       = out_word_reg;
    assign sts.remote     = remote_reg;
    assign sts.rate_limit = cfg_rate_en_reg;
    assign sts.div_busy   = div_busy;
    assign sts.div_done   = div_done;
    assign sts.out_busy   = out_valid_reg && !out_ready;

endmodule

@@ design/srtc_ctrl.sv @@
// Controller state machine that sequences one input word through the datapath.
module srtc_ctrl
    import srtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output ctrl_cmd_t cmd,
    input  dp_sts_t   sts
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PROD      = 4'd1;
    localparam logic [3:0] S_DELTA     = 4'd2;
    localparam logic [3:0] S_CLAMP     = 4'd3;
    localparam logic [3:0] S_DIFF      = 4'd4;
    localparam logic [3:0] S_MUL2      = 4'd5;
    localparam logic [3:0] S_DIVR      = 4'd6;
    localparam logic [3:0] S_DIVR_WAIT = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PROD;
                end
            end
            S_PROD:
            begin
                if (!sts.remote)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.load_prod = 1'b1;
                    state_next    = sts.rate_limit ? S_DELTA : S_CLAMP;
                end
            end
            S_DELTA:
            begin
                cmd.load_delta = 1'b1;
                state_next     = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.load_angle = 1'b1;
                state_next     = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.load_diff = 1'b1;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.load_mul2 = 1'b1;
                state_next    = S_DIVR;
            end
            S_DIVR:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVR_WAIT;
            end
            S_DIVR_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.load_rate = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The divider is never restarted while it still works on a quotient.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // A result word is never loaded over one that is still waiting.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !sts.out_busy)
        else $error("result committed over a waiting word");

    // One word at a time: after an accept the input side closes.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

endmodule

@@ design/steering_rate_limit_turn_cancel_unit.sv @@
// Top level of the steering rate limit and turn indicator cancel unit.
//
// Each input word is one joystick sample: a signed Q1.15 steering axis, the microseconds
// since the previous sample (raised to at least 1000), a remote-active flag and three
// indicator button levels. The unit scales the axis to a wheel angle in centidegrees,
// optionally clamps it to the previous angle plus or minus max_rate times the elapsed
// time, and returns one result word per sample with the angle, the absolute steering
// rate in centidegrees per second and the indicator code (off, left, right, hazard).
// A left or right indicator cancels itself once the wheel has gone past latch_on_angle
// and comes back inside release_angle faster than return_rate_min; button rising edges
// then toggle left, right and hazard. With remote_active low the result word is all
// zero and the indicator is switched off. The unit works on one word at a time. A word
// goes from the product state through the delta state (only with rate limiting on), the
// clamp, difference, multiply and divide states to the finish state, where its result
// is loaded once the output register is free; the next word can be taken in the cycle
// after that. Most of the time goes to the rate divider, which delivers one quotient
// bit per cycle; the allowed step for the rate clamp comes from a reciprocal multiply.
// A word with remote_active low goes from the product state straight to the finish
// state. The finished result sits in an output register, so the next sample is taken
// while the result still waits for out_ready. Configuration is a plain write port;
// the user must write registers only while the unit is idle, which it does not enforce.
module steering_rate_limit_turn_cancel_unit
    import srtc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_word_t                  in_word,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_word_t                 out_word,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // The controller steps each remote-active word through scale, clamp, difference and divide.
    srtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds the registers, the rate divider and the result register.
    srtc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule
